FILE: design/aacp_pkg.sv
// Package: phase codes, field tables and parser state type for the config parser.
`default_nettype none
package aacp_pkg;
	localparam logic [4:0] P_AOT   = 5'd0;
	localparam logic [4:0] P_AOTX  = 5'd1;
	localparam logic [4:0] P_SFI   = 5'd2;
	localparam logic [4:0] P_FREQ  = 5'd3;
	localparam logic [4:0] P_CH    = 5'd4;
	localparam logic [4:0] P_XSFI  = 5'd5;
	localparam logic [4:0] P_XFREQ = 5'd6;
	localparam logic [4:0] P_XAOT  = 5'd7;
	localparam logic [4:0] P_XAOTX = 5'd8;
	localparam logic [4:0] P_XCH   = 5'd9;
	localparam logic [4:0] P_FLF   = 5'd10;
	localparam logic [4:0] P_DCC   = 5'd11;
	localparam logic [4:0] P_DELAY = 5'd12;
	localparam logic [4:0] P_EXT   = 5'd13;
	localparam logic [4:0] P_LAYER = 5'd14;
	localparam logic [4:0] P_SUBF  = 5'd15;
	localparam logic [4:0] P_LLEN  = 5'd16;
	localparam logic [4:0] P_RES   = 5'd17;
	localparam logic [4:0] P_EXT3  = 5'd18;
	localparam logic [4:0] P_IDLE  = 5'd19;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic [4:0]  phase;
		logic [4:0]  left;
		logic [23:0] shift;
		logic [6:0]  otype;
		logic [3:0]  sidx;
		logic [3:0]  pidx;
		logic [23:0] rate;
		logic [3:0]  ch;
		logic [10:0] flen;
		logic        hdr;
		logic        ext;
		logic        ga;
		logic        probed;
	} parse_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  audio_obj_type;
		logic [3:0]  sampling_index;
		logic [3:0]  probed_index;
		logic [23:0] sample_rate;
		logic [3:0]  channel_config;
		logic [10:0] frame_len;
		logic        ga_complete;
		logic        config_valid;
		logic [1:0]  profile;
	} result_t;

	function automatic logic [4:0] phase_bits(input logic [4:0] p);
		case (p)
			P_AOT, P_XAOT, P_SUBF: phase_bits = 5'd5;
			P_AOTX, P_XAOTX: phase_bits = 5'd6;
			P_SFI, P_CH, P_XSFI, P_XCH: phase_bits = 5'd4;
			P_FREQ, P_XFREQ: phase_bits = 5'd24;
			P_FLF, P_DCC, P_EXT, P_EXT3: phase_bits = 5'd1;
			P_DELAY: phase_bits = 5'd14;
			P_LAYER, P_RES: phase_bits = 5'd3;
			P_LLEN: phase_bits = 5'd11;
			default: phase_bits = 5'd0;
		endcase
	endfunction

	function automatic logic [23:0] rate_of(input logic [3:0] i);
		case (i)
			4'd0: rate_of = 24'd96000;
			4'd1: rate_of = 24'd88200;
			4'd2: rate_of = 24'd64000;
			4'd3: rate_of = 24'd48000;
			4'd4: rate_of = 24'd44100;
			4'd5: rate_of = 24'd32000;
			4'd6: rate_of = 24'd24000;
			4'd7: rate_of = 24'd22050;
			4'd8: rate_of = 24'd16000;
			4'd9: rate_of = 24'd12000;
			4'd10: rate_of = 24'd11025;
			4'd11: rate_of = 24'd8000;
			4'd12: rate_of = 24'd7350;
			default: rate_of = 24'd0;
		endcase
	endfunction

	// Table 4.82 ranges; parallel compares, first match wins.
	function automatic logic [3:0] probe(input logic [23:0] f);
		if (f >= 24'd92017) probe = 4'd0;
		else if (f >= 24'd75132) probe = 4'd1;
		else if (f >= 24'd55426) probe = 4'd2;
		else if (f >= 24'd46009) probe = 4'd3;
		else if (f >= 24'd37566) probe = 4'd4;
		else if (f >= 24'd27713) probe = 4'd5;
		else if (f >= 24'd23004) probe = 4'd6;
		else if (f >= 24'd18783) probe = 4'd7;
		else if (f >= 24'd13856) probe = 4'd8;
		else if (f >= 24'd11502) probe = 4'd9;
		else if (f >= 24'd9391) probe = 4'd10;
		else probe = 4'd11;
	endfunction

	function automatic logic is_ga(input logic [6:0] t);
		case (t)
			7'd1, 7'd2, 7'd3, 7'd4, 7'd6, 7'd7, 7'd17, 7'd19, 7'd20, 7'd21, 7'd22,
			7'd23: is_ga = 1'b1;
			default: is_ga = 1'b0;
		endcase
	endfunction

	function automatic parse_t enter(input parse_t s, input logic [4:0] p);
		parse_t r;
		r = s;
		r.phase = p;
		r.left = phase_bits(p);
		r.shift = '0;
		return r;
	endfunction

	function automatic parse_t header_done(input parse_t s);
		parse_t r;
		r = s;
		r.hdr = 1'b1;
		return enter(r, is_ga(r.otype) ? P_FLF : P_IDLE);
	endfunction

	function automatic parse_t after_type2(input parse_t s);
		return (s.otype == 7'd22) ? enter(s, P_XCH) : header_done(s);
	endfunction

	function automatic parse_t ga_done(input parse_t s);
		parse_t r;
		r = s;
		r.ga = 1'b1;
		return enter(r, P_IDLE);
	endfunction

	function automatic parse_t after_layer(input parse_t s);
		parse_t r;
		if (!s.ext) r = ga_done(s);
		else if (s.otype == 7'd22) r = enter(s, P_SUBF);
		else if (s.otype == 7'd17 || s.otype == 7'd19 || s.otype == 7'd20 ||
			s.otype == 7'd23) r = enter(s, P_RES);
		else r = enter(s, P_EXT3);
		return r;
	endfunction

	function automatic parse_t finish(input parse_t s);
		parse_t r;
		logic [23:0] v;
		logic [6:0] t;
		r = s;
		v = s.shift;
		t = s.otype;
		case (s.phase)
			P_AOT: begin
				if (v[4:0] == 5'd31) r = enter(s, P_AOTX);
				else begin
					r.otype = {2'b00, v[4:0]};
					r = enter(r, P_SFI);
				end
			end
			P_AOTX: begin
				r.otype = 7'd32 + {1'b0, v[5:0]};
				r = enter(r, P_SFI);
			end
			P_SFI: begin
				r.sidx = v[3:0];
				if (v[3:0] == 4'd15) r = enter(r, P_FREQ);
				else begin
					r.rate = rate_of(v[3:0]);
					r = enter(r, P_CH);
				end
			end
			P_FREQ: begin
				r.rate = v;
				r.pidx = probe(v);
				r.probed = 1'b1;
				r = enter(r, P_CH);
			end
			P_CH: begin
				r.ch = v[3:0];
				if (t == 7'd5 || t == 7'd29) r = enter(r, P_XSFI);
				else r = header_done(r);
			end
			P_XSFI: r = enter(s, (v[3:0] == 4'd15) ? P_XFREQ : P_XAOT);
			P_XFREQ: r = enter(s, P_XAOT);
			P_XAOT: begin
				if (v[4:0] == 5'd31) r = enter(s, P_XAOTX);
				else begin
					r.otype = {2'b00, v[4:0]};
					r = after_type2(r);
				end
			end
			P_XAOTX: begin
				r.otype = 7'd32 + {1'b0, v[5:0]};
				r = after_type2(r);
			end
			P_XCH: r = header_done(s);
			P_FLF: begin
				if (t == 7'd23) r.flen = v[0] ? 11'd480 : 11'd512;
				else if (t == 7'd3) r.flen = 11'd256;
				else r.flen = v[0] ? 11'd960 : 11'd1024;
				r = enter(r, P_DCC);
			end
			P_DCC: r = enter(s, v[0] ? P_DELAY : P_EXT);
			P_DELAY: r = enter(s, P_EXT);
			P_EXT: begin
				if (v[0]) r.ext = 1'b1;
				if (t == 7'd6 || t == 7'd20) r = enter(r, P_LAYER);
				else r = after_layer(r);
			end
			P_LAYER: r = after_layer(s);
			P_SUBF: r = enter(s, P_LLEN);
			P_LLEN, P_RES: r = enter(s, P_EXT3);
			P_EXT3: r = ga_done(s);
			default: r = enter(s, P_IDLE);
		endcase
		return r;
	endfunction

	function automatic parse_t restart_state();
		parse_t r;
		r = '0;
		return enter(r, P_AOT);
	endfunction
endpackage
`default_nettype wire

FILE: design/aacp_if.sv
// Valid/ready stream interfaces for config bytes and parse results.
`default_nettype none
interface aacp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aacp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  audio_obj_type;
	logic [3:0]  sampling_index;
	logic [3:0]  probed_index;
	logic [23:0] sample_rate;
	logic [3:0]  channel_config;
	logic [10:0] frame_len;
	logic        ga_complete;
	logic        config_valid;
	logic [1:0]  profile;
	modport source (output valid, output status, output audio_obj_type, output sampling_index,
		output probed_index, output sample_rate, output channel_config, output frame_len,
		output ga_complete, output config_valid, output profile, input ready);
	modport sink (input valid, input status, input audio_obj_type, input sampling_index,
		input probed_index, input sample_rate, input channel_config, input frame_len,
		input ga_complete, input config_valid, input profile, output ready);
endinterface
`default_nettype wire

FILE: design/aacp_step.sv
// Combinational byte step: eight bit steps of the syntax walker plus result assembly.
`default_nettype none
module aacp_step (
	input  wire aacp_pkg::parse_t  cur,
	input  wire logic [4:0]        byte_count,
	input  wire logic [4:0]        min_bytes,
	input  wire logic [7:0]        data_byte,
	output aacp_pkg::parse_t       nxt,
	output logic [4:0]             nxt_count,
	output aacp_pkg::result_t      res
);
	aacp_pkg::parse_t s [0:8];
	logic [4:0] cnt;

	always_comb begin
		s[0] = cur;
		for (int i = 0; i < 8; i++) begin
			s[i+1] = s[i];
			if (s[i].phase < aacp_pkg::P_IDLE && s[i].left != 5'd0) begin
				s[i+1].shift = {s[i].shift[22:0], data_byte[7-i]};
				s[i+1].left = s[i].left - 5'd1;
				if (s[i+1].left == 5'd0) s[i+1] = aacp_pkg::finish(s[i+1]);
			end
		end
		nxt = s[8];
		cnt = (byte_count == 5'd31) ? byte_count : byte_count + 5'd1;
		nxt_count = cnt;
	end

	always_comb begin
		res = '0;
		if (cnt < min_bytes) begin
			res.status = aacp_pkg::ST_SHORT;
		end else begin
			res.status = s[8].hdr ? aacp_pkg::ST_OK : aacp_pkg::ST_TRUNC;
			res.audio_obj_type = s[8].otype;
			res.sampling_index = s[8].sidx;
			res.probed_index = s[8].probed ? s[8].pidx : 4'd15;
			res.sample_rate = s[8].rate;
			res.channel_config = s[8].ch;
			res.frame_len = s[8].flen;
			res.ga_complete = s[8].ga;
			res.config_valid = s[8].hdr && s[8].otype != 7'd0 &&
				(s[8].sidx < 4'd13 || res.probed_index < 4'd13) && s[8].ch < 4'd15;
			if (s[8].otype == 7'd1) res.profile = 2'd0;
			else if (s[8].otype == 7'd2 || s[8].otype == 7'd5 || s[8].otype == 7'd29)
				res.profile = 2'd1;
			else if (s[8].otype == 7'd3) res.profile = 2'd2;
			else res.profile = 2'd3;
		end
	end
endmodule
`default_nettype wire

FILE: design/aac_audio_config_parser_top.sv
// Top level: parser state, byte step and output register of the config parser.
// One config byte is taken per cycle, back to back; all eight bit steps of the
// AudioSpecificConfig walk run combinationally between the parse state and the
// result register. The byte marked last yields one result, registered, and the
// parser restarts for the next config. A waiting result stalls input only
// while the output register is full and not being taken.
`default_nettype none
module aac_audio_config_parser_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	aacp_in_if.sink         in_ch,
	aacp_out_if.source      out_ch
);
	aacp_pkg::parse_t  st_q, nxt;
	aacp_pkg::result_t res, res_q;
	logic [4:0] count_q, nxt_count, min_q;
	logic       vld_q;
	logic       take;

	aacp_step u_step (
		.cur(st_q), .byte_count(count_q), .min_bytes(min_q), .data_byte(in_ch.data_byte),
		.nxt(nxt), .nxt_count(nxt_count), .res(res)
	);

	assign in_ch.ready = !vld_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= aacp_pkg::restart_state();
			count_q <= '0;
			min_q <= 5'd2;
			vld_q <= 1'b0;
		end else begin
			if (cfg_we) min_q <= cfg_wdata;
			if (out_ch.ready) vld_q <= 1'b0;
			if (take) begin
				if (in_ch.last_byte) begin
					st_q <= aacp_pkg::restart_state();
					count_q <= '0;
					vld_q <= 1'b1;
				end else begin
					st_q <= nxt;
					count_q <= nxt_count;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_ch.last_byte) res_q <= res;
	end

	assign out_ch.valid = vld_q;
	assign out_ch.status = res_q.status;
	assign out_ch.audio_obj_type = res_q.audio_obj_type;
	assign out_ch.sampling_index = res_q.sampling_index;
	assign out_ch.probed_index = res_q.probed_index;
	assign out_ch.sample_rate = res_q.sample_rate;
	assign out_ch.channel_config = res_q.channel_config;
	assign out_ch.frame_len = res_q.frame_len;
	assign out_ch.ga_complete = res_q.ga_complete;
	assign out_ch.config_valid = res_q.config_valid;
	assign out_ch.profile = res_q.profile;
endmodule
`default_nettype wire

FILE: design/aacp_checker.sv
// Port-level checker for the config parser, bound to the top level.
`default_nettype none
module aacp_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic in_last,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] status,
	input wire logic config_valid
);
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with empty output");
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last))
		else $error("result without last byte");
	a_no_result_else: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_last && !(out_valid && !out_ready)) |=> !out_valid)
		else $error("spurious result");
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && config_valid) |-> status == aacp_pkg::ST_OK)
		else $error("config_valid with error status");
endmodule

bind aac_audio_config_parser_top aacp_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_last(in_ch.last_byte), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .config_valid(out_ch.config_valid)
);
`default_nettype wire
